/* hw/rtl/bpsu_pkg.sv */
// Shared types, register indexes and constants of the BMP pixel stream unpacker.
`default_nettype none
package bpsu_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] REG_BIT_DEPTH    = 3'd0;
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
	localparam logic [2:0] REG_RAW_RGB_MODE = 3'd3;
	localparam logic [2:0] REG_DATA_OFFSET  = 3'd4;

	localparam logic [5:0]  BIT_DEPTH_RST    = 6'd24;
	localparam logic [15:0] DATA_OFFSET_RST  = 16'd54;

	localparam logic [5:0] DEPTH_16 = 6'd16;
	localparam logic [5:0] DEPTH_24 = 6'd24;
	localparam logic [5:0] DEPTH_32 = 6'd32;

	localparam logic [2:0] BPP_2 = 3'd2;
	localparam logic [2:0] BPP_3 = 3'd3;

	typedef struct packed {
		logic [5:0]  bit_depth;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        raw_rgb_mode;
		logic [15:0] data_offset;
	} cfg_t;

	// One classified byte handed from the front to the back.
	typedef struct packed {
		logic [7:0] byte_in;
		logic       load_row;
		logic       is_data;
	} cmd_t;

	typedef struct packed {
		logic [15:0] row;
		logic [15:0] column;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last_pixel;
	} pix_t;

endpackage
`default_nettype wire

/* hw/rtl/bmp_pixel_stream_unpacker.sv */
// Each pixel is built from 2-4 bytes and reaches the result ports through both queues.
// Throughput: one byte per cycle, set by the back end's one-byte step, while no queue is full.
// Queues of QUEUE_DEPTH entries sit between front and back and before the result ports.
// Reset (arst_n low) clears all counters and queues and returns registers to reset values.
// A new file needs a reset; register writes do not clear the decoder state.
`default_nettype none
module bmp_pixel_stream_unpacker #(
	parameter int unsigned QUEUE_DEPTH = bpsu_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bpsu_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bpsu_pkg::DATA_W-1:0]   pwdata,
	output logic [bpsu_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          push,
	input  wire logic [7:0]                    byte_in,
	output logic                               full,
	input  wire logic                          pop,
	output logic                               empty,
	output logic [15:0]                        row,
	output logic [15:0]                        column,
	output logic [7:0]                         red,
	output logic [7:0]                         green,
	output logic [7:0]                         blue,
	output logic [7:0]                         alpha,
	output logic                               last_pixel
);
	bpsu_pkg::cfg_t cfg_q;
	bpsu_pkg::cmd_t f_cmd;
	bpsu_pkg::cmd_t b_cmd;
	bpsu_pkg::pix_t b_pix;
	bpsu_pkg::pix_t o_pix;

	logic       wr_en;
	logic [2:0] reg_idx;
	logic       take;
	logic       cmd_push;
	logic       cmd_full;
	logic       cmd_empty;
	logic       cmd_pop;
	logic       out_push;
	logic       out_full;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_depth    <= bpsu_pkg::BIT_DEPTH_RST;
			cfg_q.image_width  <= '0;
			cfg_q.image_height <= '0;
			cfg_q.raw_rgb_mode <= 1'b1;
			cfg_q.data_offset  <= bpsu_pkg::DATA_OFFSET_RST;
		end else if (wr_en) begin
			case (reg_idx)
				bpsu_pkg::REG_BIT_DEPTH:    cfg_q.bit_depth    <= pwdata[5:0];
				bpsu_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[15:0];
				bpsu_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[15:0];
				bpsu_pkg::REG_RAW_RGB_MODE: cfg_q.raw_rgb_mode <= pwdata[0];
				bpsu_pkg::REG_DATA_OFFSET:  cfg_q.data_offset  <= pwdata[15:0];
				default:                    cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bpsu_pkg::REG_BIT_DEPTH:    prdata = {26'd0, cfg_q.bit_depth};
			bpsu_pkg::REG_IMAGE_WIDTH:  prdata = {16'd0, cfg_q.image_width};
			bpsu_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, cfg_q.image_height};
			bpsu_pkg::REG_RAW_RGB_MODE: prdata = {31'd0, cfg_q.raw_rgb_mode};
			bpsu_pkg::REG_DATA_OFFSET:  prdata = {16'd0, cfg_q.data_offset};
			default:                    prdata = '0;
		endcase
	end

	assign full = cmd_full;
	assign take = push && !cmd_full;

	bpsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.take     (take),
		.byte_in  (byte_in),
		.cmd_push (cmd_push),
		.cmd      (f_cmd)
	);

	bpsu_fifo #(
		.WIDTH ($bits(bpsu_pkg::cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (f_cmd),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (b_cmd),
		.empty  (cmd_empty)
	);

	bpsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (b_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.pix       (b_pix)
	);

	bpsu_fifo #(
		.WIDTH ($bits(bpsu_pkg::pix_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (b_pix),
		.full   (out_full),
		.pop    (pop),
		.rdata  (o_pix),
		.empty  (empty)
	);

	assign row        = o_pix.row;
	assign column     = o_pix.column;
	assign red        = o_pix.red;
	assign green      = o_pix.green;
	assign blue       = o_pix.blue;
	assign alpha      = o_pix.alpha;
	assign last_pixel = o_pix.last_pixel;

endmodule
`default_nettype wire

/* hw/rtl/bpsu_fifo.sv */
// Small first-in first-out queue with registered storage.
`default_nettype none
module bpsu_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = bpsu_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop_ok) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/bpsu_front.sv */
// Front end: counts header bytes and classifies each file byte for the back end.
`default_nettype none
module bpsu_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bpsu_pkg::cfg_t cfg,
	input  wire logic          take,
	input  wire logic [7:0]    byte_in,
	output logic               cmd_push,
	output bpsu_pkg::cmd_t     cmd
);
	logic [16:0] pos_q;
	logic [16:0] offset_ext;
	logic        skip;
	logic        at_offset;
	logic        data_ok;

	assign offset_ext = {1'b0, cfg.data_offset};
	assign skip       = (pos_q < offset_ext);
	assign at_offset  = (pos_q == offset_ext);

	assign data_ok = cfg.raw_rgb_mode && (cfg.image_width != '0) && (cfg.image_height != '0)
		&& ((cfg.bit_depth == bpsu_pkg::DEPTH_16) || (cfg.bit_depth == bpsu_pkg::DEPTH_24)
		|| (cfg.bit_depth == bpsu_pkg::DEPTH_32));

	assign cmd.byte_in  = byte_in;
	assign cmd.load_row = at_offset;
	assign cmd.is_data  = !skip && data_ok;
	// drop header bytes and bytes that can never form a pixel
	assign cmd_push     = take && (cmd.load_row || cmd.is_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (skip) begin
				pos_q <= pos_q + 17'd1;
			end else if (at_offset) begin
				pos_q <= offset_ext + 17'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/bpsu_back.sv */
// Back end: strips row padding, gathers pixel bytes and emits pixels with coordinates.
`default_nettype none
module bpsu_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bpsu_pkg::cfg_t cfg,
	input  wire bpsu_pkg::cmd_t cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	input  wire logic           out_full,
	output logic                out_push,
	output bpsu_pkg::pix_t      pix
);
	logic [15:0] row_q;
	logic [15:0] col_q;
	logic [1:0]  bip_q;
	logic [23:0] held_q;
	logic [1:0]  pad_q;
	logic        done_q;

	logic [2:0]  bpp;
	logic [2:0]  bpp_m1;
	logic [15:0] row_cur;
	logic [15:0] width_m1;
	logic        active;
	logic        gather;
	logic        row_end;
	logic [15:0] word;
	logic [1:0]  pad_next;

	assign bpp      = cfg.bit_depth[5:3];
	assign bpp_m1   = bpp - 3'd1;
	assign width_m1 = cfg.image_width - 16'd1;
	assign row_cur  = cmd.load_row ? (cfg.image_height - 16'd1) : row_q;

	assign cmd_pop  = !cmd_empty && !out_full;
	assign active   = cmd_pop && cmd.is_data && !done_q && (pad_q == '0);
	assign gather   = ({1'b0, bip_q} < bpp_m1);
	assign out_push = active && !gather;
	assign row_end  = (col_q >= width_m1);
	assign word     = {cmd.byte_in, held_q[7:0]};
	// pad to a 4-byte row: minus (bpp * width) mod 4
	assign pad_next = 2'd0 - 2'(bpp[1:0] * cfg.image_width[1:0]);

	always_comb begin
		pix.row        = row_cur;
		pix.column     = col_q;
		pix.last_pixel = row_end && (row_cur == '0);
		case (bpp)
			bpsu_pkg::BPP_2: begin
				pix.red   = {word[14:10], 3'b000};
				pix.green = {word[9:5], 3'b000};
				pix.blue  = {word[4:0], 3'b000};
				pix.alpha = 8'd0;
			end
			bpsu_pkg::BPP_3: begin
				pix.red   = cmd.byte_in;
				pix.green = held_q[15:8];
				pix.blue  = held_q[7:0];
				pix.alpha = 8'd0;
			end
			default: begin
				pix.red   = held_q[23:16];
				pix.green = held_q[15:8];
				pix.blue  = held_q[7:0];
				pix.alpha = cmd.byte_in;
			end
		endcase
	end

	// gathered bytes: each slot is written before it is read
	always_ff @(posedge clk) begin
		if (active && gather) begin
			case (bip_q)
				2'd0:    held_q[7:0]   <= cmd.byte_in;
				2'd1:    held_q[15:8]  <= cmd.byte_in;
				2'd2:    held_q[23:16] <= cmd.byte_in;
				default: held_q        <= held_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			bip_q  <= '0;
			pad_q  <= '0;
			done_q <= 1'b0;
		end else if (cmd_pop) begin
			row_q <= row_cur;
			if (cmd.is_data && !done_q) begin
				if (pad_q != '0) begin
					pad_q <= pad_q - 2'd1;
				end else if (gather) begin
					bip_q <= bip_q + 2'd1;
				end else begin
					bip_q <= '0;
					if (row_end) begin
						col_q <= '0;
						pad_q <= pad_next;
						if (row_cur == '0) begin
							done_q <= 1'b1;
						end else begin
							row_q <= row_cur - 16'd1;
						end
					end else begin
						col_q <= col_q + 16'd1;
					end
				end
			end
		end
	end

	a_no_pixel_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !done_q)
		else $error("pixel emitted after the final pixel");

	a_done_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(out_push && pix.last_pixel))
		else $error("image done without a final pixel beat");

	a_pad_between_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q != '0) |-> (bip_q == '0))
		else $error("row padding pending inside a pixel");

endmodule
`default_nettype wire

/* tb/bmp_pixel_check_pkg.sv */
// Predictor and scoreboard for the BMP pixel stream unpacker testbench.
`timescale 1ns / 1ps
package bmp_pixel_check_pkg;
	import bpsu_pkg::*;

	class bmp_pixel_predictor;
		logic [5:0]  depth;
		logic [15:0] width;
		logic [15:0] height;
		logic        raw_mode;
		logic [15:0] offset;

		logic [16:0] pos;
		logic [15:0] row_cnt;
		logic [15:0] col_cnt;
		logic [1:0]  byte_idx;
		logic [23:0] held;
		logic [1:0]  pad_left;
		bit          done;

		pix_t        expected_pixels[$];
		int unsigned mismatches;
		int unsigned pixels_checked;
		int unsigned bytes_seen;

		function new();
			depth = BIT_DEPTH_RST;
			width = '0;
			height = '0;
			raw_mode = 1'b1;
			offset = DATA_OFFSET_RST;
			pos = '0;
			row_cnt = '0;
			col_cnt = '0;
			byte_idx = '0;
			held = '0;
			pad_left = '0;
			done = 1'b0;
			mismatches = 0;
			pixels_checked = 0;
			bytes_seen = 0;
		endfunction

		// Update the register copy; return what a read-back should show.
		function logic [31:0] store_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_BIT_DEPTH: begin
					depth = val[5:0];
					return {26'd0, depth};
				end
				REG_IMAGE_WIDTH: begin
					width = val[15:0];
					return {16'd0, width};
				end
				REG_IMAGE_HEIGHT: begin
					height = val[15:0];
					return {16'd0, height};
				end
				REG_RAW_RGB_MODE: begin
					raw_mode = val[0];
					return {31'd0, raw_mode};
				end
				REG_DATA_OFFSET: begin
					offset = val[15:0];
					return {16'd0, offset};
				end
				default: return 32'd0;
			endcase
		endfunction

		function void note_byte(logic [7:0] b);
			logic [2:0]  bpp;
			logic [15:0] word;
			int unsigned row_bytes;
			pix_t        px;

			bytes_seen++;
			if (pos < {1'b0, offset}) begin
				pos++;
				return;
			end
			if (pos == {1'b0, offset}) begin
				row_cnt = height - 16'd1;
				pos = {1'b0, offset} + 17'd1;
			end
			if (!raw_mode || done || width == 16'd0 || height == 16'd0)
				return;
			if (depth != DEPTH_16 && depth != DEPTH_24 && depth != DEPTH_32)
				return;
			if (pad_left != 2'd0) begin
				pad_left--;
				return;
			end

			bpp = depth[5:3];
			if (byte_idx < bpp - 3'd1) begin
				held = held | (24'(b) << (8 * byte_idx));
				byte_idx++;
				return;
			end

			word = {b, held[7:0]};
			case (bpp)
				BPP_2: begin
					px.red   = {word[14:10], 3'b000};
					px.green = {word[9:5], 3'b000};
					px.blue  = {word[4:0], 3'b000};
					px.alpha = 8'd0;
				end
				BPP_3: begin
					px.red   = b;
					px.green = held[15:8];
					px.blue  = held[7:0];
					px.alpha = 8'd0;
				end
				default: begin
					px.red   = held[23:16];
					px.green = held[15:8];
					px.blue  = held[7:0];
					px.alpha = b;
				end
			endcase
			px.row = row_cnt;
			px.column = col_cnt;
			px.last_pixel = 1'b0;
			byte_idx = '0;
			held = '0;

			if (col_cnt >= width - 16'd1) begin
				col_cnt = '0;
				row_bytes = bpp * width;
				pad_left = 2'((4 - (row_bytes & 3)) & 3);
				if (row_cnt == 16'd0) begin
					done = 1'b1;
					px.last_pixel = 1'b1;
				end else begin
					row_cnt--;
				end
			end else begin
				col_cnt++;
			end
			expected_pixels.push_back(px);
		endfunction

		function void check_pixel(pix_t got);
			pix_t want;
			bit   bad;

			if (expected_pixels.size() == 0) begin
				$error("pixel with no pending byte: row %0d column %0d", got.row, got.column);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			pixels_checked++;
			bad = 1'b0;
			if (got.row !== want.row) begin
				$error("row: expected %0d, got %0d", want.row, got.row);
				bad = 1'b1;
			end
			if (got.column !== want.column) begin
				$error("column: expected %0d, got %0d", want.column, got.column);
				bad = 1'b1;
			end
			if (got.red !== want.red) begin
				$error("red: expected %h, got %h", want.red, got.red);
				bad = 1'b1;
			end
			if (got.green !== want.green) begin
				$error("green: expected %h, got %h", want.green, got.green);
				bad = 1'b1;
			end
			if (got.blue !== want.blue) begin
				$error("blue: expected %h, got %h", want.blue, got.blue);
				bad = 1'b1;
			end
			if (got.alpha !== want.alpha) begin
				$error("alpha: expected %h, got %h", want.alpha, got.alpha);
				bad = 1'b1;
			end
			if (got.last_pixel !== want.last_pixel) begin
				$error("last_pixel: expected %b, got %b", want.last_pixel, got.last_pixel);
				bad = 1'b1;
			end
			if (bad)
				mismatches++;
		endfunction
	endclass

endpackage

/* tb/bmp_pixel_stream_unpacker_test.sv */
// Top-level testbench of the BMP pixel stream unpacker: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
module bmp_pixel_stream_unpacker_test;
	import bpsu_pkg::*;
	import bmp_pixel_check_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_PHASES = 30;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              push;
	logic [7:0]        byte_in;
	logic              full;
	logic              pop;
	logic              empty;
	logic [15:0]       row;
	logic [15:0]       column;
	logic [7:0]        red;
	logic [7:0]        green;
	logic [7:0]        blue;
	logic [7:0]        alpha;
	logic              last_pixel;

	bmp_pixel_predictor predictor = new();

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_cycles;
	int unsigned cycle_count = 0;
	int unsigned settings_applied = 0;

	bmp_pixel_stream_unpacker dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .byte_in(byte_in), .full(full),
		.pop(pop), .empty(empty),
		.row(row), .column(column), .red(red), .green(green), .blue(blue),
		.alpha(alpha), .last_pixel(last_pixel)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random pop, or a counted hold-off when one is requested.
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				pop <= 1'b0;
				hold_cycles--;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
			@(posedge clk);
			if (pop && !empty)
				predictor.check_pixel({row, column, red, green, blue, alpha, last_pixel});
		end
	end

	task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] stored;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		stored = predictor.store_reg(idx, val);
		// read back through a fresh setup phase
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) begin
			$error("prdata of register %0d: expected %h, got %h", idx, stored, prdata);
			predictor.mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drain the block, let in-flight bytes settle, then load a full setting.
	task automatic apply_setting(input logic [5:0] d, input logic [15:0] w, input logic [15:0] h,
			input logic raw, input logic [15:0] off);
		@(negedge clk);
		push <= 1'b0;
		while (predictor.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		program_reg(REG_BIT_DEPTH, 32'(d));
		program_reg(REG_IMAGE_WIDTH, 32'(w));
		program_reg(REG_IMAGE_HEIGHT, 32'(h));
		program_reg(REG_RAW_RGB_MODE, 32'(raw));
		program_reg(REG_DATA_OFFSET, 32'(off));
		settings_applied++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		gap = 0;
		if (send_idle_pct != 0)
			while ($urandom_range(0, 99) < send_idle_pct)
				gap++;
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (full);
		predictor.note_byte(b);
	endtask

	initial begin
		int          i;
		int          phase;
		int unsigned n;
		int unsigned kind;
		logic [5:0]  d;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] off;
		logic        raw;
		logic [7:0]  pattern [12];

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		push = 1'b0;
		byte_in = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 0;
		pattern = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE,
			8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty image: the byte at the offset still reloads the row count, to 65535.
		apply_setting(DEPTH_24, 16'd3, 16'd0, 1'b1, 16'd0);
		send_byte(8'h00);
		// Rows now start at 65535; three 24-bit pixels and three padding bytes.
		apply_setting(DEPTH_24, 16'd3, 16'hFFFF, 1'b1, 16'd0);
		for (i = 0; i < 12; i++)
			send_byte(pattern[i]);
		apply_setting(DEPTH_32, 16'd1, 16'hFFFF, 1'b1, 16'd0);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'h7F);
		apply_setting(DEPTH_16, 16'd1, 16'hFFFF, 1'b1, 16'd0);
		send_byte(8'hFF);
		send_byte(8'h7F);
		send_byte(8'h00);
		send_byte(8'hFF);
		// Compressed data and unsupported depths drop bytes.
		apply_setting(DEPTH_24, 16'd1, 16'hFFFF, 1'b0, 16'd0);
		send_byte(8'hA5);
		apply_setting(6'h3F, 16'd1, 16'hFFFF, 1'b1, 16'd0);
		send_byte(8'h5A);
		apply_setting(6'h00, 16'd1, 16'hFFFF, 1'b1, 16'd0);
		send_byte(8'hC3);
		apply_setting(DEPTH_24, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase / 10)
				0: begin
					send_idle_pct = 19;
					recv_idle_pct = 65;
				end
				1: begin
					send_idle_pct = 65;
					recv_idle_pct = 19;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			kind = $urandom_range(0, 9);
			if (kind < 3)
				d = DEPTH_16;
			else if (kind < 6)
				d = DEPTH_24;
			else if (kind < 9)
				d = DEPTH_32;
			else
				d = 6'($urandom);

			kind = $urandom_range(0, 19);
			if (kind < 17)
				w = 16'($urandom_range(1, 7));
			else if (kind == 17)
				w = 16'd0;
			else if (kind == 18)
				w = 16'hFFFF;
			else
				w = 16'($urandom);

			// Keep heights tall so the image never completes before the tail.
			kind = $urandom_range(0, 19);
			if (kind < 9)
				h = 16'hFFFF;
			else if (kind < 18)
				h = 16'($urandom_range(2000, 65535));
			else
				h = 16'd0;

			raw = ($urandom_range(0, 9) != 0);

			// Often raise the offset to skip a short stretch and reload the rows; else set it to 65535 or below the position.
			kind = $urandom_range(0, 99);
			if (kind < 40)
				off = 16'(predictor.pos + $urandom_range(0, 12));
			else if (kind < 43)
				off = 16'hFFFF;
			else if (predictor.pos == 0)
				off = 16'd0;
			else
				off = 16'($urandom_range(0, predictor.pos - 1));

			apply_setting(d, w, h, raw, off);
			if (phase == 0 || phase == 20)
				hold_cycles = 300;
			n = $urandom_range(30, 70);
			repeat (n) send_byte(8'($urandom));
		end

		// Tail: a two-row image reloaded at once, run to its last pixel and past it.
		apply_setting(DEPTH_24, 16'd2, 16'd2, 1'b1, 16'(predictor.pos));
		repeat (40) send_byte(8'($urandom));

		@(negedge clk);
		push <= 1'b0;
		while (predictor.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d file bytes and %0d checked pixels over %0d register settings,",
			predictor.bytes_seen, predictor.pixels_checked, settings_applied);
		$display("with three idle profiles, long result stalls and bytes past the final pixel.");
		if (predictor.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
